>>> sv/bf93_pkg.sv
// Shared constants, types and decode function of the Befunge-93 step engine.
`timescale 1ns / 1ps
package bf93_pkg;

  localparam int FIELD_COLS  = 80;
  localparam int FIELD_ROWS  = 25;
  localparam int STACK_DEPTH = 1024;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;

  localparam int PF_DEPTH = FIELD_COLS * FIELD_ROWS;
  localparam int PF_AW    = $clog2(PF_DEPTH);
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int CNT_W    = STK_AW + 1;
  localparam int DIV_CW   = $clog2(WORD_W + 1);

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_PCT    = 8'h25;
  localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_BTICK  = 8'h60;
  localparam logic [BYTE_W-1:0] CH_LOW_G  = 8'h67;
  localparam logic [BYTE_W-1:0] CH_LOW_P  = 8'h70;
  localparam logic [BYTE_W-1:0] CH_LOW_V  = 8'h76;
  localparam logic [BYTE_W-1:0] CH_PIPE   = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_RIGHT = 2'd3
  } head_t;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_NUM  = 2'd1,
    EMIT_CHR  = 2'd2
  } emit_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_STRTOG, OP_PUSHC, OP_HEAD, OP_RAND, OP_BRIDGE, OP_HALT,
    OP_DROP, OP_DUP, OP_HIF, OP_VIF, OP_OUTNUM, OP_OUTCHR, OP_NOT, OP_IN,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_SWAP, OP_GET, OP_PUT
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FETCH, ST_DECODE, ST_POP_RD, ST_POP_CAP,
    ST_EXEC, ST_DIV_WAIT, ST_DIV_FIN, ST_GET_RD, ST_GET_CAP, ST_PUSH0, ST_PUSH1,
    ST_ADV1, ST_ADV2, ST_DONE
  } state_t;

  typedef struct packed {
    logic       clr_wr;
    logic       capture;
    logic       load_wr;
    logic       decode;
    logic       pop_rd;
    logic       pop_cap;
    logic [1:0] pop_slot;
    logic       exec;
    logic       div_fin;
    logic       get_rd;
    logic       get_cap;
    logic       push0;
    logic       push1;
    logic       adv;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       kind;
    logic       halted;
    op_t        op_now;
    op_t        op;
    logic [1:0] npush;
  } dp_stat_t;

  function automatic op_t bf93_decode(input logic [BYTE_W-1:0] c, input logic smode);
    op_t op;
    op = OP_NOP;
    if (c == CH_QUOTE) op = OP_STRTOG;
    else if (smode) op = OP_PUSHC;
    else if (c >= CH_ZERO && c <= CH_NINE) op = OP_PUSHC;
    else begin
      priority case (c)
        CH_LT, CH_GT, CH_CARET, CH_LOW_V: op = OP_HEAD;
        CH_QUEST:  op = OP_RAND;
        CH_HASH:   op = OP_BRIDGE;
        CH_AT:     op = OP_HALT;
        CH_DOLLAR: op = OP_DROP;
        CH_COLON:  op = OP_DUP;
        CH_UNDER:  op = OP_HIF;
        CH_PIPE:   op = OP_VIF;
        CH_DOT:    op = OP_OUTNUM;
        CH_COMMA:  op = OP_OUTCHR;
        CH_BANG:   op = OP_NOT;
        CH_AMP, CH_TILDE: op = OP_IN;
        CH_PLUS:   op = OP_ADD;
        CH_MINUS:  op = OP_SUB;
        CH_STAR:   op = OP_MUL;
        CH_SLASH:  op = OP_DIV;
        CH_PCT:    op = OP_MOD;
        CH_BTICK:  op = OP_GT;
        CH_BSLASH: op = OP_SWAP;
        CH_LOW_G:  op = OP_GET;
        CH_LOW_P:  op = OP_PUT;
        default:   op = OP_NOP;
      endcase
    end
    return op;
  endfunction

  function automatic logic [1:0] op_pops(input op_t op);
    logic [1:0] n;
    n = 2'd0;
    unique case (op)
      OP_DROP, OP_DUP, OP_HIF, OP_VIF, OP_OUTNUM, OP_OUTCHR, OP_NOT: n = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_SWAP, OP_GET: n = 2'd2;
      OP_PUT:  n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/bf93_if.sv
// Valid/ready channel interfaces for step items and their results.
`timescale 1ns / 1ps
interface bf93_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [bf93_pkg::COL_W-1:0]    cell_col;
  logic [bf93_pkg::ROW_W-1:0]    cell_row;
  logic [bf93_pkg::BYTE_W-1:0]   cell_byte;
  logic signed [bf93_pkg::WORD_W-1:0] input_number;
  logic [1:0]                    random_turn;

  modport source (output valid, kind, cell_col, cell_row, cell_byte, input_number,
                  random_turn, input ready);
  modport sink (input valid, kind, cell_col, cell_row, cell_byte, input_number,
                random_turn, output ready);
endinterface

interface bf93_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    emit_kind;
  logic signed [bf93_pkg::WORD_W-1:0] emit_value;
  logic                          stopped;
  logic [bf93_pkg::COL_W-1:0]    next_col;
  logic [bf93_pkg::ROW_W-1:0]    next_row;
  logic                          overflow;
  logic                          wants_input;

  modport source (output valid, emit_kind, emit_value, stopped, next_col, next_row,
                  overflow, wants_input, input ready);
  modport sink (input valid, emit_kind, emit_value, stopped, next_col, next_row,
                overflow, wants_input, output ready);
endinterface

>>> sv/bf93_div.sv
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bf93_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bf93_pkg::WORD_W-1:0]   dvd,
  input  logic [bf93_pkg::WORD_W-1:0]   dvs,
  output logic                          done,
  output logic [bf93_pkg::WORD_W-1:0]   quo,
  output logic [bf93_pkg::WORD_W-1:0]   rem
);
  import bf93_pkg::*;

  logic [WORD_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [WORD_W:0]   rem_sh, diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[WORD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (!diff[WORD_W]) begin
      rem_nxt = diff[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(WORD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dvd;
      dvs_r <= dvs;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

>>> sv/bf93_datapath.sv
// Datapath: playfield and stack memories, machine registers and result register.
`timescale 1ns / 1ps
module bf93_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bf93_pkg::dp_cmd_t                 cmd,
  output bf93_pkg::dp_stat_t                stat,
  input  logic                              in_kind,
  input  logic [bf93_pkg::COL_W-1:0]        in_cell_col,
  input  logic [bf93_pkg::ROW_W-1:0]        in_cell_row,
  input  logic [bf93_pkg::BYTE_W-1:0]       in_cell_byte,
  input  logic [bf93_pkg::WORD_W-1:0]       in_input_number,
  input  logic [1:0]                        in_random_turn,
  output logic [bf93_pkg::WORD_W-1:0]       div_dvd,
  output logic [bf93_pkg::WORD_W-1:0]       div_dvs,
  input  logic [bf93_pkg::WORD_W-1:0]       div_quo,
  input  logic [bf93_pkg::WORD_W-1:0]       div_rem,
  output logic [1:0]                        out_emit_kind,
  output logic [bf93_pkg::WORD_W-1:0]       out_emit_value,
  output logic                              out_stopped,
  output logic [bf93_pkg::COL_W-1:0]        out_next_col,
  output logic [bf93_pkg::ROW_W-1:0]        out_next_row,
  output logic                              out_overflow,
  output logic                              out_wants_input
);
  import bf93_pkg::*;

  logic [BYTE_W-1:0] pf_mem [PF_DEPTH];
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];

  logic              kind_r;
  logic [COL_W-1:0]  col_r, pc_col_r;
  logic [ROW_W-1:0]  row_r, pc_row_r;
  logic [BYTE_W-1:0] byte_r, pf_q_r, imm_r;
  logic [WORD_W-1:0] num_r, stk_q_r, res0_r, res1_r, emit_val_r;
  logic [1:0]        turn_r, npush_r;
  head_t             head_r;
  emit_t             emit_r;
  logic              smode_r, halted_r, ovf_r, wants_r, pop_empty_r, empty0_r, ginr_r;
  logic              op_smode_r;
  logic [CNT_W-1:0]  cnt_r, cnt_m1;
  logic [PF_AW-1:0]  clr_addr_r;
  logic              clr_done_r;
  op_t               op_r;
  logic [WORD_W-1:0] p_r [3];

  logic [1:0]        out_kind_r;
  logic [WORD_W-1:0] out_val_r;
  logic              out_stop_r, out_ovf_r, out_wants_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;

  logic              pf_we;
  logic [PF_AW-1:0]  pf_wa, pf_ra, pc_addr, g_addr;
  logic [BYTE_W-1:0] pf_wd;
  logic              g_in, stk_we, stk_full, load_in;
  logic [WORD_W-1:0] stk_wd, a_w, b_w, ua, ub, divq;
  logic              na, nb;

  assign a_w  = p_r[1];
  assign b_w  = p_r[0];
  assign na   = a_w[WORD_W-1];
  assign nb   = b_w[WORD_W-1];
  assign ua   = na ? (WORD_W'(0) - a_w) : a_w;
  assign ub   = nb ? (WORD_W'(0) - b_w) : b_w;
  assign div_dvd = ua;
  assign div_dvs = ub;

  assign pc_addr = PF_AW'(pc_row_r) * PF_AW'(FIELD_COLS) + PF_AW'(pc_col_r);
  assign g_addr  = PF_AW'(b_w[ROW_W-1:0]) * PF_AW'(FIELD_COLS) + PF_AW'(a_w[COL_W-1:0]);
  assign g_in    = !a_w[WORD_W-1] && (a_w < WORD_W'(FIELD_COLS)) &&
                   !b_w[WORD_W-1] && (b_w < WORD_W'(FIELD_ROWS));
  assign load_in = (int'(col_r) < FIELD_COLS) && (int'(row_r) < FIELD_ROWS);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign stk_full = !(int'(cnt_r) < STACK_DEPTH);

  // Playfield write port: clearing sweep, load items and the put instruction.
  always_comb begin
    pf_we = 1'b0;
    pf_wa = pc_addr;
    pf_wd = CH_SPACE;
    if (cmd.clr_wr) begin
      pf_we = 1'b1;
      pf_wa = clr_addr_r;
    end else if (cmd.load_wr) begin
      pf_we = load_in;
      pf_wa = PF_AW'(row_r) * PF_AW'(FIELD_COLS) + PF_AW'(col_r);
      pf_wd = byte_r;
    end else if (cmd.exec && op_r == OP_PUT) begin
      pf_we = g_in;
      pf_wa = g_addr;
      pf_wd = p_r[2][BYTE_W-1:0];
    end
    pf_ra = cmd.get_rd ? g_addr : pc_addr;
  end

  always_ff @(posedge clk) begin
    if (pf_we) pf_mem[pf_wa] <= pf_wd;
    pf_q_r <= pf_mem[pf_ra];
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wd = res0_r;
    if (cmd.push0) begin
      stk_we = (npush_r != 2'd0) && !stk_full;
    end else if (cmd.push1) begin
      stk_we = !stk_full;
      stk_wd = res1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[cnt_r[STK_AW-1:0]] <= stk_wd;
    stk_q_r <= stk_mem[cnt_m1[STK_AW-1:0]];
  end

  always_comb begin
    unique case (op_r)
      OP_DIV:  divq = (b_w == '0) ? '0 : ((na != nb) ? (WORD_W'(0) - div_quo) : div_quo);
      default: divq = (b_w == '0) ? '0 : (na ? (WORD_W'(0) - div_rem) : div_rem);
    endcase
  end

  // Machine control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_col_r   <= '0;
      pc_row_r   <= '0;
      head_r     <= HEAD_RIGHT;
      smode_r    <= 1'b0;
      halted_r   <= 1'b0;
      cnt_r      <= '0;
      clr_addr_r <= '0;
      clr_done_r <= 1'b0;
      ovf_r      <= 1'b0;
      wants_r    <= 1'b0;
      emit_r     <= EMIT_NONE;
      op_r       <= OP_NOP;
      npush_r    <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + PF_AW'(1);
        if (clr_addr_r == PF_AW'(PF_DEPTH - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.capture) begin
        ovf_r   <= 1'b0;
        wants_r <= 1'b0;
        emit_r  <= EMIT_NONE;
      end
      if (cmd.decode) begin
        op_r    <= bf93_decode(pf_q_r, smode_r);
        npush_r <= '0;
      end
      if (cmd.pop_rd && cnt_r != '0) cnt_r <= cnt_m1;
      if (stk_we) cnt_r <= cnt_r + CNT_W'(1);
      if ((cmd.push0 && npush_r != 2'd0 && stk_full) || (cmd.push1 && stk_full))
        ovf_r <= 1'b1;
      if (cmd.exec) begin
        // The push count is already zero from decode unless an arm sets it.
        unique case (op_r)
          OP_STRTOG: smode_r <= !smode_r;
          OP_PUSHC, OP_NOT, OP_IN, OP_ADD, OP_SUB, OP_MUL, OP_GT: npush_r <= 2'd1;
          OP_HEAD: begin
            priority case (imm_r)
              CH_LT:    head_r <= HEAD_LEFT;
              CH_CARET: head_r <= HEAD_UP;
              CH_LOW_V: head_r <= HEAD_DOWN;
              default:  head_r <= HEAD_RIGHT;
            endcase
          end
          OP_RAND:   head_r   <= head_t'(turn_r);
          OP_HALT:   halted_r <= 1'b1;
          OP_DUP:    npush_r  <= empty0_r ? 2'd1 : 2'd2;
          OP_HIF:    head_r   <= (b_w != '0) ? HEAD_LEFT : HEAD_RIGHT;
          OP_VIF:    head_r   <= (b_w != '0) ? HEAD_UP : HEAD_DOWN;
          OP_OUTNUM: emit_r   <= EMIT_NUM;
          OP_OUTCHR: emit_r   <= EMIT_CHR;
          OP_SWAP:   npush_r  <= 2'd2;
          default:   npush_r  <= 2'd0;
        endcase
        if (op_r == OP_IN) wants_r <= 1'b1;
      end
      if (cmd.div_fin || cmd.get_cap) npush_r <= 2'd1;
      if (cmd.adv) begin
        unique case (head_r)
          HEAD_UP:   pc_row_r <= (pc_row_r == '0) ? ROW_W'(FIELD_ROWS - 1) :
                                 pc_row_r - ROW_W'(1);
          HEAD_DOWN: pc_row_r <= (pc_row_r == ROW_W'(FIELD_ROWS - 1)) ? '0 :
                                 pc_row_r + ROW_W'(1);
          HEAD_LEFT: pc_col_r <= (pc_col_r == '0) ? COL_W'(FIELD_COLS - 1) :
                                 pc_col_r - COL_W'(1);
          default:   pc_col_r <= (pc_col_r == COL_W'(FIELD_COLS - 1)) ? '0 :
                                 pc_col_r + COL_W'(1);
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r     <= in_kind;
      col_r      <= in_cell_col;
      row_r      <= in_cell_row;
      byte_r     <= in_cell_byte;
      num_r      <= in_input_number;
      turn_r     <= in_random_turn;
      emit_val_r <= '0;
    end
    if (cmd.decode) begin
      imm_r      <= pf_q_r;
      op_smode_r <= smode_r;
    end
    if (cmd.pop_rd) pop_empty_r <= (cnt_r == '0);
    if (cmd.pop_cap) begin
      p_r[cmd.pop_slot] <= pop_empty_r ? '0 : stk_q_r;
      if (cmd.pop_slot == 2'd0) empty0_r <= pop_empty_r;
    end
    if (cmd.exec) begin
      // Swap pushes the old top first and then the word below it.
      res1_r <= (op_r == OP_SWAP) ? a_w : b_w;
      unique case (op_r)
        OP_PUSHC:  res0_r <= op_smode_r ? WORD_W'(imm_r) : WORD_W'(imm_r - CH_ZERO);
        OP_NOT:    res0_r <= (b_w == '0) ? WORD_W'(1) : '0;
        OP_IN:     res0_r <= num_r;
        OP_ADD:    res0_r <= a_w + b_w;
        OP_SUB:    res0_r <= a_w - b_w;
        OP_MUL:    res0_r <= a_w * b_w;
        OP_GT:     res0_r <= ($signed(a_w) > $signed(b_w)) ? WORD_W'(1) : '0;
        OP_OUTNUM, OP_OUTCHR: begin
          res0_r     <= b_w;
          emit_val_r <= b_w;
        end
        default:   res0_r <= b_w;
      endcase
    end
    if (cmd.div_fin) res0_r <= divq;
    if (cmd.get_rd)  ginr_r <= g_in;
    if (cmd.get_cap) res0_r <= ginr_r ? WORD_W'(pf_q_r) : '0;
    if (cmd.out_load) begin
      out_kind_r  <= emit_r;
      out_val_r   <= emit_val_r;
      out_stop_r  <= halted_r;
      out_col_r   <= pc_col_r;
      out_row_r   <= pc_row_r;
      out_ovf_r   <= ovf_r;
      out_wants_r <= wants_r;
    end
  end

  assign stat.clr_done = clr_done_r || (cmd.clr_wr && clr_addr_r == PF_AW'(PF_DEPTH - 1));
  assign stat.kind     = kind_r;
  assign stat.halted   = halted_r;
  assign stat.op_now   = bf93_decode(pf_q_r, smode_r);
  assign stat.op       = op_r;
  assign stat.npush    = npush_r;

  assign out_emit_kind   = out_kind_r;
  assign out_emit_value  = out_val_r;
  assign out_stopped     = out_stop_r;
  assign out_next_col    = out_col_r;
  assign out_next_row    = out_row_r;
  assign out_overflow    = out_ovf_r;
  assign out_wants_input = out_wants_r;
endmodule

>>> sv/bf93_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module bf93_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bf93_pkg::dp_stat_t stat,
  input  logic               div_done,
  output logic               div_start,
  output bf93_pkg::dp_cmd_t  cmd
);
  import bf93_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  logic       out_valid_r;
  logic       out_free;
  state_t     after_push;

  assign out_free   = !out_valid_r || out_ready;
  assign after_push = (stat.op == OP_HALT) ? ST_DONE : ST_ADV1;

  always_comb begin
    state_nxt = state_r;
    pcnt_nxt  = pcnt_r;
    unique case (state_r)
      ST_CLEAR:    if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!stat.kind || stat.halted) state_nxt = ST_DONE;
        else state_nxt = ST_FETCH;
      end
      ST_FETCH:    state_nxt = ST_DECODE;
      ST_DECODE: begin
        pcnt_nxt  = 2'd0;
        state_nxt = (op_pops(stat.op_now) != 2'd0) ? ST_POP_RD : ST_EXEC;
      end
      ST_POP_RD:   state_nxt = ST_POP_CAP;
      ST_POP_CAP: begin
        if (pcnt_r == op_pops(stat.op) - 2'd1) begin
          state_nxt = (stat.op == OP_GET) ? ST_GET_RD : ST_EXEC;
        end else begin
          pcnt_nxt  = pcnt_r + 2'd1;
          state_nxt = ST_POP_RD;
        end
      end
      ST_EXEC: begin
        if (stat.op == OP_DIV || stat.op == OP_MOD) state_nxt = ST_DIV_WAIT;
        else state_nxt = ST_PUSH0;
      end
      ST_DIV_WAIT: if (div_done) state_nxt = ST_DIV_FIN;
      ST_DIV_FIN:  state_nxt = ST_PUSH0;
      ST_GET_RD:   state_nxt = ST_GET_CAP;
      ST_GET_CAP:  state_nxt = ST_PUSH0;
      ST_PUSH0:    state_nxt = (stat.npush == 2'd2) ? ST_PUSH1 : after_push;
      ST_PUSH1:    state_nxt = after_push;
      ST_ADV1:     state_nxt = (stat.op == OP_BRIDGE) ? ST_ADV2 : ST_DONE;
      ST_ADV2:     state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    div_start = 1'b0;
    in_ready  = (state_r == ST_IDLE);
    cmd.pop_slot = pcnt_r;
    unique case (state_r)
      ST_CLEAR:    cmd.clr_wr  = 1'b1;
      ST_IDLE:     cmd.capture = in_valid;
      ST_DISPATCH: cmd.load_wr = !stat.kind;
      ST_DECODE:   cmd.decode  = 1'b1;
      ST_POP_RD:   cmd.pop_rd  = 1'b1;
      ST_POP_CAP:  cmd.pop_cap = 1'b1;
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        div_start = (stat.op == OP_DIV || stat.op == OP_MOD);
      end
      ST_DIV_FIN:  cmd.div_fin = 1'b1;
      ST_GET_RD:   cmd.get_rd  = 1'b1;
      ST_GET_CAP:  cmd.get_cap = 1'b1;
      ST_PUSH0:    cmd.push0   = 1'b1;
      ST_PUSH1:    cmd.push1   = 1'b1;
      ST_ADV1, ST_ADV2: cmd.adv = 1'b1;
      ST_DONE:     cmd.out_load = out_free;
      default:     cmd.pop_slot = pcnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pcnt_r  <= pcnt_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> sv/befunge93_step_engine_unit.sv
// Top level of the Befunge-93 step engine: controller, datapath and divider.
`timescale 1ns / 1ps
// The engine runs a Befunge-93 program on an 80 by 25 wrapping playfield with a
// 1024-word value stack. Each input transaction either loads one playfield cell
// or executes the instruction under the program counter, and each one produces
// exactly one result transaction that reports printed output, the halted flag,
// the new program counter, a dropped push and whether the input value was used.
// After reset the engine fills the playfield with spaces, one cell per cycle,
// and does not accept a transaction until that is done.
// Items are handled one at a time. A load, and a step after the halt, goes from
// acceptance straight to the result register; a step fetches and decodes the
// cell, pops its operands (up to three), executes, pushes its results and moves
// the counter, with an extra read for a get, a second move for a bridge and the
// bit-serial divider for divide and modulo, while a halt does not move. The
// playfield and stack memories each have one write port and one registered
// read port. The engine takes the next transaction in the cycle after a
// result is loaded. The result sits in an output register, so the next item is
// accepted and worked on while a result waits; it only stalls in its last
// cycle until that register frees up.
module befunge93_step_engine_unit (
  input  logic         clk,
  input  logic         rst_n,
  bf93_in_if.sink      in_ch,
  bf93_out_if.source   out_ch
);
  import bf93_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic [WORD_W-1:0] emit_value;

  // The controller owns the handshakes and the step sequence.
  bf93_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .div_done  (div_done),
    .div_start (div_start),
    .cmd       (cmd)
  );

  // The datapath holds all machine state and the result register.
  bf93_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_cell_col     (in_ch.cell_col),
    .in_cell_row     (in_ch.cell_row),
    .in_cell_byte    (in_ch.cell_byte),
    .in_input_number (in_ch.input_number),
    .in_random_turn  (in_ch.random_turn),
    .div_dvd         (div_dvd),
    .div_dvs         (div_dvs),
    .div_quo         (div_quo),
    .div_rem         (div_rem),
    .out_emit_kind   (out_ch.emit_kind),
    .out_emit_value  (emit_value),
    .out_stopped     (out_ch.stopped),
    .out_next_col    (out_ch.next_col),
    .out_next_row    (out_ch.next_row),
    .out_overflow    (out_ch.overflow),
    .out_wants_input (out_ch.wants_input)
  );

  // Magnitudes go in; the datapath fixes up signs and the zero divisor case.
  bf93_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign out_ch.emit_value = $signed(emit_value);
endmodule

>>> sv/bf93_checker.sv
// Port-level checker for the step engine and its bind to the top level.
`timescale 1ns / 1ps
module bf93_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_emit_kind,
  input logic [bf93_pkg::WORD_W-1:0]  out_emit_value,
  input logic [bf93_pkg::COL_W-1:0]   out_next_col,
  input logic [bf93_pkg::ROW_W-1:0]   out_next_row,
  input logic                         out_wants_input
);
  import bf93_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_emit_value) &&
    $stable(out_next_col) && $stable(out_next_row))
    else $error("result changed while stalled");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_next_col) < FIELD_COLS) && (int'(out_next_row) < FIELD_ROWS))
    else $error("program counter outside the playfield");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_kind == EMIT_NONE |-> out_emit_value == '0)
    else $error("value reported without output");

  a_io_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_wants_input && out_emit_kind != EMIT_NONE) &&
    out_emit_kind != 2'd3)
    else $error("inconsistent output and input flags");
endmodule

bind befunge93_step_engine_unit bf93_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_emit_kind   (out_ch.emit_kind),
  .out_emit_value  (out_ch.emit_value),
  .out_next_col    (out_ch.next_col),
  .out_next_row    (out_ch.next_row),
  .out_wants_input (out_ch.wants_input)
);

>>> tb/befunge93_step_engine_unit_tb.sv
// Self-checking testbench for the Befunge-93 step engine: runs programs and checks each result.
`timescale 1ns / 1ps
module befunge93_step_engine_unit_tb;
  import bf93_pkg::*;

  // The run is bounded by this many clock cycles. The slowest legal run is a few
  // thousand items, each at worst a divide plus a long sender gap and a long
  // receiver stall, after the playfield clear.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 550;

  logic clk;
  logic rst_n;

  bf93_in_if  in_ch();
  bf93_out_if out_ch();

  befunge93_step_engine_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // One input transaction: a cell load or an instruction step.
  typedef struct {
    bit        kind;
    bit [6:0]  col;
    bit [4:0]  row;
    bit [7:0]  cell_val;
    bit [31:0] num;
    bit [1:0]  turn;
  } bf_item_t;

  // One result transaction as the engine should report it.
  typedef struct {
    bit [1:0]  emit_kind;
    bit [31:0] emit_value;
    bit        stopped;
    bit [6:0]  ncol;
    bit [4:0]  nrow;
    bit        ovf;
    bit        wants;
  } bf_result_t;

  bf_item_t   pending_items[$];
  bf_result_t expected_results[$];

  // Shadow copy of the machine, advanced as the item list is built.
  bit [7:0]    field_mem [FIELD_COLS*FIELD_ROWS];
  bit [31:0]   stack_mem [STACK_DEPTH];
  int          depth_cnt;
  int          pc_col;
  int          pc_row;
  head_t       heading;
  bit          str_mode;
  bit          halted_f;
  bit          push_dropped;

  int errors;
  int sent_cnt;
  int got_cnt;
  int total_items;
  int cycle_cnt;

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow machine.
  // ---------------------------------------------------------------------------
  function automatic void push_word(bit [31:0] v);
    if (depth_cnt >= STACK_DEPTH) begin
      push_dropped = 1'b1;
    end else begin
      stack_mem[depth_cnt] = v;
      depth_cnt++;
    end
  endfunction

  // An empty stack yields zero.
  function automatic bit [31:0] pop_word();
    if (depth_cnt == 0) return 32'd0;
    depth_cnt--;
    return stack_mem[depth_cnt];
  endfunction

  // The playfield is a torus, so the counter wraps on every edge.
  function automatic void move_pc();
    case (heading)
      HEAD_UP:    pc_row = (pc_row == 0) ? FIELD_ROWS - 1 : pc_row - 1;
      HEAD_DOWN:  pc_row = (pc_row + 1 >= FIELD_ROWS) ? 0 : pc_row + 1;
      HEAD_LEFT:  pc_col = (pc_col == 0) ? FIELD_COLS - 1 : pc_col - 1;
      default:    pc_col = (pc_col + 1 >= FIELD_COLS) ? 0 : pc_col + 1;
    endcase
  endfunction

  // Signed division truncating toward zero; a zero divisor gives zero, and the
  // most negative value over minus one wraps back to itself.
  function automatic bit [31:0] signed_div(bit [31:0] a, bit [31:0] b, bit want_rem);
    bit [31:0] ua;
    bit [31:0] ub;
    bit [31:0] r;
    if (b == 32'd0) return 32'd0;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    if (want_rem) begin
      r = ua % ub;
      return a[31] ? -r : r;
    end
    r = ua / ub;
    return (a[31] != b[31]) ? -r : r;
  endfunction

  function automatic bit coord_ok(bit [31:0] c, bit [31:0] r);
    return !c[31] && !r[31] && $signed(c) < FIELD_COLS && $signed(r) < FIELD_ROWS;
  endfunction

  // Applies one item to the shadow machine and returns the result it causes.
  function automatic bf_result_t run_item(bf_item_t it);
    bf_result_t res;
    bit [7:0]   c;
    bit [31:0]  a;
    bit [31:0]  b;
    bit [31:0]  v;
    bit         moves;
    res = '{default: 0};
    push_dropped = 1'b0;
    if (!it.kind) begin
      // Loads outside the field are silently ignored.
      if (it.col < FIELD_COLS && it.row < FIELD_ROWS)
        field_mem[it.row * FIELD_COLS + it.col] = it.cell_val;
    end else if (!halted_f) begin
      c = field_mem[pc_row * FIELD_COLS + pc_col];
      moves = 1'b1;
      if (c == CH_QUOTE) str_mode = !str_mode;
      else if (str_mode) push_word({24'd0, c});
      else if (c >= CH_ZERO && c <= CH_NINE) push_word({24'd0, c - CH_ZERO});
      else begin
        case (c)
          CH_LT:     heading = HEAD_LEFT;
          CH_GT:     heading = HEAD_RIGHT;
          CH_CARET:  heading = HEAD_UP;
          CH_LOW_V:  heading = HEAD_DOWN;
          CH_QUEST:  heading = head_t'(it.turn);
          CH_HASH:   move_pc();
          CH_AT: begin
            halted_f = 1'b1;
            moves = 1'b0;
          end
          CH_DOLLAR: v = pop_word();
          CH_COLON:  push_word(depth_cnt == 0 ? 32'd0 : stack_mem[depth_cnt-1]);
          CH_UNDER:  heading = (pop_word() != 0) ? HEAD_LEFT : HEAD_RIGHT;
          CH_PIPE:   heading = (pop_word() != 0) ? HEAD_UP : HEAD_DOWN;
          CH_DOT: begin
            res.emit_kind = EMIT_NUM;
            res.emit_value = pop_word();
          end
          CH_COMMA: begin
            res.emit_kind = EMIT_CHR;
            res.emit_value = pop_word();
          end
          CH_BANG:   push_word(pop_word() == 0 ? 32'd1 : 32'd0);
          CH_AMP, CH_TILDE: begin
            res.wants = 1'b1;
            push_word(it.num);
          end
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_BTICK, CH_BSLASH,
          CH_LOW_G: begin
            b = pop_word();
            a = pop_word();
            case (c)
              CH_PLUS:  push_word(a + b);
              CH_MINUS: push_word(a - b);
              CH_STAR:  push_word(a * b);
              CH_SLASH: push_word(signed_div(a, b, 1'b0));
              CH_PCT:   push_word(signed_div(a, b, 1'b1));
              CH_BTICK: push_word($signed(a) > $signed(b) ? 32'd1 : 32'd0);
              CH_BSLASH: begin
                push_word(b);
                push_word(a);
              end
              default:
                push_word(coord_ok(a, b) ?
                          {24'd0, field_mem[int'(b) * FIELD_COLS + int'(a)]} : 32'd0);
            endcase
          end
          CH_LOW_P: begin
            // All three pops happen even when the target is off the field.
            b = pop_word();
            a = pop_word();
            v = pop_word();
            if (coord_ok(a, b)) field_mem[int'(b) * FIELD_COLS + int'(a)] = v[7:0];
          end
          default: ;
        endcase
      end
      if (moves) move_pc();
    end
    res.stopped = halted_f;
    res.ncol = 7'(pc_col);
    res.nrow = 5'(pc_row);
    res.ovf = push_dropped;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item list construction.
  // ---------------------------------------------------------------------------
  function automatic void add_item(bf_item_t it);
    pending_items.push_back(it);
    expected_results.push_back(run_item(it));
  endfunction

  function automatic bf_item_t make_item(bit kind, int col, int row, bit [7:0] ch,
                                         bit [31:0] num);
    bf_item_t it;
    it.kind = kind;
    it.col = 7'(col);
    it.row = 5'(row);
    it.cell_val = ch;
    it.num = num;
    it.turn = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // A plain step; a halt stored by an earlier put is painted over first so that
  // the program only stops at the very end of the run.
  function automatic void add_step(bit [31:0] num);
    if (!str_mode && field_mem[pc_row * FIELD_COLS + pc_col] == CH_AT)
      add_item(make_item(1'b0, pc_col, pc_row, CH_SPACE, $urandom));
    add_item(make_item(1'b1, $urandom_range(0, 127), $urandom_range(0, 31),
                       8'($urandom_range(0, 255)), num));
  endfunction

  // Writes an instruction under the counter and runs it.
  function automatic void run_op(bit [7:0] ch, bit [31:0] num);
    add_item(make_item(1'b0, pc_col, pc_row, ch, $urandom));
    add_item(make_item(1'b1, $urandom_range(0, 127), $urandom_range(0, 31),
                       8'($urandom_range(0, 255)), num));
  endfunction

  function automatic bit [31:0] wide_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return $urandom;
      default: return $urandom_range(0, 90);
    endcase
  endfunction

  task automatic build_items();
    string ops;
    bit [7:0] ch;
    int row;
    ops = "0123456789+-*/%!`><^v?_|\":\\$.,#gp&~ ";

    // Directed part: empty-stack pops, division extremes, zero divisor,
    // off-field get and put, input extremes, string mode and an off-field load.
    run_op(CH_DOT, $urandom);
    run_op(CH_AMP, 32'h8000_0000);
    run_op(CH_TILDE, 32'hFFFF_FFFF);
    run_op(CH_SLASH, $urandom);
    run_op(CH_COMMA, $urandom);
    run_op(CH_NINE, $urandom);
    run_op(CH_ZERO, $urandom);
    run_op(CH_PCT, $urandom);
    run_op(CH_AMP, 32'hFFFF_FFF9);
    run_op(CH_AMP, 32'hFFFF_FFFF);
    run_op(CH_LOW_G, $urandom);
    run_op(CH_AMP, 32'd200);
    run_op(CH_LOW_P, $urandom);
    add_item(make_item(1'b0, 127, 31, 8'hFF, 32'hFFFF_FFFF));
    run_op(CH_QUOTE, $urandom);
    add_step($urandom);

    // Random part: mostly instructions planted under the counter and run, with
    // plain steps over whatever lies ahead and stray loads anywhere.
    while (pending_items.size() < RANDOM_ITEMS + 30) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_op(ops[$urandom_range(0, ops.len() - 1)], wide_value());
        6, 7: add_step(wide_value());
        8: begin
          ch = 8'($urandom_range(0, 255));
          if (ch == CH_AT) ch = CH_SPACE;
          add_item(make_item(1'b0, $urandom_range(0, 127), $urandom_range(0, 31), ch,
                             $urandom));
        end
        default: run_op($urandom_range(0, 1) ? CH_AMP : CH_TILDE, wide_value());
      endcase
    end

    // Stack-full phase: leave string mode, head right along a row of duplicates
    // and keep stepping until pushes are dropped.
    while (str_mode) run_op(CH_QUOTE, $urandom);
    run_op(CH_GT, $urandom);
    row = pc_row;
    for (int c = 0; c < FIELD_COLS; c++)
      add_item(make_item(1'b0, c, row, CH_COLON, $urandom));
    while (depth_cnt < STACK_DEPTH) add_step($urandom);
    repeat (3) add_step($urandom);

    // Halt, then steps that change nothing and a load that still lands.
    run_op(CH_AT, $urandom);
    add_step($urandom);
    add_item(make_item(1'b0, 5, 5, CH_PLUS, $urandom));
    add_step($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued transactions, changing inputs on the falling edge.
  // ---------------------------------------------------------------------------
  bit in_taken;
  bit offering;
  int send_gap;

  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) sent_cnt++;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(negedge clk) begin
    bf_item_t it;
    bit pause;
    if (rst_n) begin
      if (offering && in_taken) begin
        offering = 1'b0;
        // A stretch of back-to-back items every few hundred transactions.
        send_gap = (sent_cnt % 400 < 80) ? 0 : pick_gap();
      end
      // Once, the sender waits for the engine to drain completely.
      pause = (sent_cnt == 300) && (got_cnt < sent_cnt);
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0 && !pause) begin
          it = pending_items.pop_front();
          in_ch.kind <= it.kind;
          in_ch.cell_col <= it.col;
          in_ch.cell_row <= it.row;
          in_ch.cell_byte <= it.cell_val;
          in_ch.input_number <= it.num;
          in_ch.random_turn <= it.turn;
          offering = 1'b1;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off that backs up the engine.
  // ---------------------------------------------------------------------------
  int stall_cnt;
  int hold_cnt;
  bit hold_done;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (!hold_done && got_cnt >= 200) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end else if (got_cnt % 400 >= 80 && $urandom_range(0, 5) == 0) begin
        stall_cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(1, 3);
      end
      out_ch.ready <= (hold_cnt == 0) && (stall_cnt == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every result transaction with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bf_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_cnt++;
      if (expected_results.size() == 0) begin
        $error("result transaction with no expected result pending");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.emit_kind !== exp_r.emit_kind) begin
          $error("emit_kind: expected %0d, got %0d", exp_r.emit_kind, out_ch.emit_kind);
          errors++;
        end
        if (out_ch.emit_value !== exp_r.emit_value) begin
          $error("emit_value: expected %0d, got %0d", $signed(exp_r.emit_value),
                 out_ch.emit_value);
          errors++;
        end
        if (out_ch.stopped !== exp_r.stopped) begin
          $error("stopped: expected %0d, got %0d", exp_r.stopped, out_ch.stopped);
          errors++;
        end
        if (out_ch.next_col !== exp_r.ncol) begin
          $error("next_col: expected %0d, got %0d", exp_r.ncol, out_ch.next_col);
          errors++;
        end
        if (out_ch.next_row !== exp_r.nrow) begin
          $error("next_row: expected %0d, got %0d", exp_r.nrow, out_ch.next_row);
          errors++;
        end
        if (out_ch.overflow !== exp_r.ovf) begin
          $error("overflow: expected %0d, got %0d", exp_r.ovf, out_ch.overflow);
          errors++;
        end
        if (out_ch.wants_input !== exp_r.wants) begin
          $error("wants_input: expected %0d, got %0d", exp_r.wants, out_ch.wants_input);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, stimulus build and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.cell_col = '0;
    in_ch.cell_row = '0;
    in_ch.cell_byte = '0;
    in_ch.input_number = '0;
    in_ch.random_turn = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < FIELD_COLS * FIELD_ROWS; i++) field_mem[i] = CH_SPACE;
    depth_cnt = 0;
    pc_col = 0;
    pc_row = 0;
    heading = HEAD_RIGHT;
    str_mode = 1'b0;
    halted_f = 1'b0;
    build_items();
    total_items = pending_items.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (got_cnt >= total_items);
    // Give a stray extra result time to show up.
    repeat (100) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
